/* hdl/adc_scan_oversampling_averager_core_assert.svh */
// Assertion macros shared by the averager modules.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef ADC_SCAN_OVERSAMPLING_AVERAGER_CORE_ASSERT_SVH
`define ADC_SCAN_OVERSAMPLING_AVERAGER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AVG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AVG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/adc_avg_pkg.sv */
package adc_avg_pkg;

  // Default build values
  localparam int MAX_SLOTS_DEF   = 4;
  localparam int SAMPLE_BITS_DEF = 12;

  // Fixed field widths of the stream and configuration ports
  localparam int SAMPLE_W   = 12;
  localparam int SLOT_IN_W  = 2;
  localparam int SUPPLY_W   = 13;
  localparam int AVG_OUT_W  = 12;
  localparam int MV_W       = 13;
  localparam int TGT_W      = 10;
  localparam int ACT_W      = 3;
  localparam int NUM_TGT    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  // Divisor width of the shared divider (holds a target or the full-scale code)
  localparam int DVS_W = 12;

  localparam logic [DVS_W-1:0] FULL_SCALE = 12'd4095;
  localparam logic [MV_W-1:0]  MV_MAX     = 13'd8191;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT3   = 3'd4;

  // Request kinds carried in tuser
  localparam logic REQ_EVENT = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // Control into and status out of the shared divider
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

/* hdl/adc_avg_div.sv */
`include "adc_scan_oversampling_averager_core_assert.svh"

module adc_avg_div #(
  parameter int DivW = 25
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  adc_avg_pkg::div_ctl_t           div_ctl,
  input  logic [DivW-1:0]                 div_dividend,
  input  logic [adc_avg_pkg::DVS_W-1:0]   div_divisor,
  output adc_avg_pkg::div_sts_t           div_sts,
  output logic [DivW-1:0]                 div_quot
);
  import adc_avg_pkg::*;

  localparam int CntW = $clog2(DivW + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [DivW-1:0] dvd_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;

  logic [DVS_W:0]  rem_sh;
  logic [DVS_W:0]  diff;
  logic            qbit;

  // One restoring step: shift in the next dividend bit and try the subtraction.
  assign rem_sh = {rem_r, dvd_r[DivW-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign qbit   = ~diff[DVS_W];

  // Step counter and handshake flags.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (div_ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CntW'(DivW);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - CntW'(1);
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath: the dividend register fills up with quotient bits from the bottom.
  always_ff @(posedge clk) begin
    if (div_ctl.start) begin
      dvd_r <= div_dividend;
      dvs_r <= div_divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DivW-2:0], qbit};
      rem_r <= qbit ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign div_sts.busy = busy_r;
  assign div_sts.done = done_r;
  assign div_quot     = dvd_r;

  `AVG_ASSERT_NEXT(a_div_start_busy, div_ctl.start, busy_r, "divider did not start")
  `AVG_ASSERT_NEXT(a_div_done_idle, done_r && !div_ctl.start, !busy_r,
                   "divider still busy after done")
  `AVG_ASSERT_NOW(a_div_cnt_live, busy_r, cnt_r != '0, "divider busy with empty count")

endmodule

/* hdl/adc_scan_oversampling_averager_core.sv */
// Status events are taken whenever the core is idle and give no result beat.
// A ready read with a nonzero target steps through S_DIV1, S_MUL, S_DIV2 and S_OUT, with
// two passes of the shared one-bit-per-cycle divider; other reads go straight to S_OUT.
// No new item is taken until the beat enters the output register, which is held off
// while an earlier beat still waits for the sink.
// Synchronous active-low reset clears all slot sums, counts and the scan position.
`include "adc_scan_oversampling_averager_core_assert.svh"

module adc_scan_oversampling_averager_core #(
  parameter int MaxSlots   = adc_avg_pkg::MAX_SLOTS_DEF,
  parameter int SampleBits = adc_avg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // tdata: eoc_flag[0], eos_flag[1], sample[13:2], slot[15:14], supply_mv[28:16]
  input  logic [adc_avg_pkg::IN_DATA_W-1:0]     in_tdata,
  // tuser: req_type
  input  logic                                  in_tuser,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // tdata: average_raw[11:0], millivolts[24:12]
  output logic [adc_avg_pkg::OUT_DATA_W-1:0]    out_tdata,
  // tuser: ready_res
  output logic                                  out_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_we,
  input  logic [adc_avg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [adc_avg_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import adc_avg_pkg::*;

  localparam int SumW  = SampleBits + TGT_W;
  localparam int DivW  = SampleBits + SUPPLY_W;
  localparam int SlotW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
  localparam int WrW   = ($clog2(MaxSlots + 1) > ACT_W) ? $clog2(MaxSlots + 1) : ACT_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV1 = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV2 = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  // Unpacked input fields
  logic                  in_eoc;
  logic                  in_eos;
  logic [SAMPLE_W-1:0]   in_sample;
  logic [SLOT_IN_W-1:0]  in_slot;
  logic [SUPPLY_W-1:0]   in_supply;

  assign in_eoc    = in_tdata[0];
  assign in_eos    = in_tdata[1];
  assign in_sample = in_tdata[13:2];
  assign in_slot   = in_tdata[15:14];
  assign in_supply = in_tdata[28:16];

  // State
  state_t              state_r, state_nxt;
  logic [ACT_W-1:0]    active_r;
  logic [TGT_W-1:0]    tgt_r [NUM_TGT];
  logic [SumW-1:0]     sum_r [MaxSlots];
  logic [TGT_W-1:0]    cnt_r [MaxSlots];
  logic [SlotW-1:0]    scan_pos_r, scan_pos_nxt;
  logic [TGT_W-1:0]    slot_tgt [MaxSlots];

  // Result staging and output register
  logic                res_ready_r, res_ready_nxt;
  logic [SampleBits-1:0] avg_r, avg_nxt;
  logic [MV_W-1:0]     mv_r, mv_nxt;
  logic [SUPPLY_W-1:0] supply_r;
  logic                out_valid_r, out_valid_nxt;
  logic                out_ready_r;
  logic [AVG_OUT_W-1:0] out_avg_r;
  logic [MV_W-1:0]     out_mv_r;

  // Shared divider
  div_ctl_t            div_ctl;
  div_sts_t            div_sts;
  logic [DivW-1:0]     div_dividend;
  logic [DVS_W-1:0]    div_divisor;
  logic [DivW-1:0]     div_quot;

  logic                in_acc;
  logic                ev_acc;
  logic                rd_acc;
  logic                out_load;
  logic                slot_ok;
  logic                rd_ready;
  logic [SumW-1:0]     rd_sum;
  logic [TGT_W-1:0]    rd_cnt;
  logic [TGT_W-1:0]    rd_tgt;
  logic [TGT_W-1:0]    pos_cnt;
  logic [TGT_W-1:0]    pos_tgt;
  logic                pos_take;
  logic [SampleBits-1:0] samp;
  logic [WrW-1:0]      act_ext;
  logic [WrW-1:0]      wrap;
  logic [WrW-1:0]      pos_inc;
  logic [DivW-1:0]     prod;
  logic [SampleBits+AVG_OUT_W-1:0] avg_ext;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign ev_acc    = in_acc && (in_tuser == REQ_EVENT);
  assign rd_acc    = in_acc && (in_tuser == REQ_READ);
  assign samp      = SampleBits'(in_sample);

  // Effective target per slot; slots past the register file keep a target of one.
  for (genvar g = 0; g < MaxSlots; g++) begin : g_tgt
    if (g < NUM_TGT) begin : g_reg
      assign slot_tgt[g] = tgt_r[g];
    end else begin : g_fix
      assign slot_tgt[g] = TGT_W'(1);
    end
  end

  // Select the slot under the scan position and the slot asked for by a read.
  always_comb begin
    rd_sum  = '0;
    rd_cnt  = '0;
    rd_tgt  = '0;
    pos_cnt = '0;
    pos_tgt = '0;
    for (int i = 0; i < MaxSlots; i++) begin
      if (int'(in_slot) == i) begin
        rd_sum = sum_r[i];
        rd_cnt = cnt_r[i];
        rd_tgt = slot_tgt[i];
      end
      if (int'(scan_pos_r) == i) begin
        pos_cnt = cnt_r[i];
        pos_tgt = slot_tgt[i];
      end
    end
  end

  assign slot_ok  = 32'(in_slot) < 32'(MaxSlots);
  assign rd_ready = slot_ok && (rd_cnt >= rd_tgt);
  assign pos_take = pos_cnt < pos_tgt;

  // Scan position: advance on end of conversion, wrap at the clamped slot count,
  // and return to zero on end of sequence.
  always_comb begin
    act_ext = WrW'(active_r);
    if (active_r == '0) begin
      wrap = WrW'(1);
    end else if (act_ext > WrW'(MaxSlots)) begin
      wrap = WrW'(MaxSlots);
    end else begin
      wrap = act_ext;
    end
    pos_inc      = WrW'(scan_pos_r) + WrW'(1);
    scan_pos_nxt = scan_pos_r;
    if (ev_acc && in_eoc) begin
      scan_pos_nxt = (pos_inc >= wrap) ? '0 : pos_inc[SlotW-1:0];
    end
    if (ev_acc && in_eos) begin
      scan_pos_nxt = '0;
    end
  end

  // Slot accumulators: add on a taken conversion, clear when a ready read is answered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MaxSlots; i++) begin
        sum_r[i] <= '0;
        cnt_r[i] <= '0;
      end
      scan_pos_r <= '0;
    end else begin
      for (int i = 0; i < MaxSlots; i++) begin
        if (ev_acc && in_eoc && pos_take && (int'(scan_pos_r) == i)) begin
          sum_r[i] <= sum_r[i] + SumW'(samp);
          cnt_r[i] <= cnt_r[i] + TGT_W'(1);
        end
        if (rd_acc && rd_ready && (int'(in_slot) == i)) begin
          sum_r[i] <= '0;
          cnt_r[i] <= '0;
        end
      end
      scan_pos_r <= scan_pos_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACT_W'(1);
      for (int i = 0; i < NUM_TGT; i++) begin
        tgt_r[i] <= TGT_W'(1);
      end
    end else if (cfg_we) begin
      if (cfg_index == CFG_ACTIVE) begin
        active_r <= cfg_wdata[ACT_W-1:0];
      end
      for (int i = 0; i < NUM_TGT; i++) begin
        if (cfg_index == CFG_TGT0 + CFG_IDX_W'(i)) begin
          tgt_r[i] <= cfg_wdata[TGT_W-1:0];
        end
      end
    end
  end

  // Divider operands: the slot sum by its target, then the scaled product by full scale.
  assign prod         = DivW'(avg_r) * DivW'(supply_r);
  assign div_dividend = (state_r == S_MUL) ? prod : DivW'(rd_sum);
  assign div_divisor  = (state_r == S_MUL) ? FULL_SCALE : DVS_W'(rd_tgt);
  assign div_ctl.start = (rd_acc && rd_ready && (rd_tgt != '0)) || (state_r == S_MUL);

  adc_avg_div #(
    .DivW (DivW)
  ) u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .div_ctl      (div_ctl),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_sts      (div_sts),
    .div_quot     (div_quot)
  );

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // Read sequencer.
  always_comb begin
    state_nxt     = state_r;
    res_ready_nxt = res_ready_r;
    avg_nxt       = avg_r;
    mv_nxt        = mv_r;
    unique case (state_r)
      S_IDLE: begin
        if (rd_acc) begin
          res_ready_nxt = rd_ready;
          avg_nxt       = '0;
          mv_nxt        = '0;
          if (rd_ready && (rd_tgt != '0)) begin
            state_nxt = S_DIV1;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_DIV1: begin
        if (div_sts.done) begin
          if (div_quot > DivW'({SampleBits{1'b1}})) begin
            avg_nxt = '1;
          end else begin
            avg_nxt = div_quot[SampleBits-1:0];
          end
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_DIV2;
      end
      S_DIV2: begin
        if (div_sts.done) begin
          if (div_quot > DivW'(MV_MAX)) begin
            mv_nxt = MV_MAX;
          end else begin
            mv_nxt = div_quot[MV_W-1:0];
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_ready_r <= res_ready_nxt;
    avg_r       <= avg_nxt;
    mv_r        <= mv_nxt;
    if (rd_acc) begin
      supply_r <= in_supply;
    end
  end

  // Output register: holds a finished beat until the sink takes it.
  assign avg_ext = (SampleBits + AVG_OUT_W)'(avg_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ready_r <= res_ready_r;
      out_avg_r   <= avg_ext[AVG_OUT_W-1:0];
      out_mv_r    <= mv_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ready_r;
  assign out_tdata  = OUT_DATA_W'({out_mv_r, out_avg_r});

  `AVG_ASSERT_NEXT(a_read_blocks, in_tvalid && in_tready && in_tuser, !in_tready,
                   "read request did not hold off the input")
  `AVG_ASSERT_NOW(a_div_free, div_ctl.start, !div_sts.busy,
                  "divider started while busy")
  `AVG_ASSERT_NOW(a_notready_zero, out_tvalid && !out_tuser, out_tdata == '0,
                  "not-ready result carries data")

endmodule
